// ===== rtl/blmsf_pkg.sv =====
// Shared types and constants of the battery level median and slew filter.
package blmsf_pkg;

  localparam int unsigned RAW_W   = 9;
  localparam int unsigned LEVEL_W = 7;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 7'd0;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } seq_state_t;

endpackage

// ===== rtl/battery_level_median_slew_filter.sv =====
// Sequence: a word is taken, then one held sample per cycle is ranked until the median is found,
// then the result is loaded into the output register once that is free, raising out_tvalid.
// Flow: one word at a time; no new word is taken while a scan runs or a result waits to be loaded.
// A finished result waits in S_EMIT until the output register is free; the next word is taken once it is loaded.
// Reset (rst_n low, synchronous) empties the ring, clears the level, drops out_tvalid and in_tready.
module battery_level_median_slew_filter import blmsf_pkg::*; #(
  parameter int unsigned WINDOW = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [8:0] raw_percent (signed), [15:9] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] shown_percent, [13:7] median_percent, [15:14] zero
  output logic        out_tuser   // [0] shown_valid
);

  localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);

  seq_state_t      state_r, state_nxt;
  logic [IW-1:0]   cand_r, cand_nxt;
  level_t          median_r, median_nxt;
  level_t          shown_r, shown_nxt;
  logic            valid_r, valid_nxt;
  logic            out_valid_r, out_valid_nxt;
  level_t          out_shown_r, out_shown_nxt;
  level_t          out_median_r, out_median_nxt;

  logic            in_accept;
  logic [RAW_W-1:0] raw;
  level_t          sample;
  level_t          cand_val;
  level_t          entries [WINDOW];
  logic [CW-1:0]   held_count;
  logic [CW-1:0]   lt_count, eq_count;
  logic [CW-1:0]   rank_k;
  logic [CW:0]     upper;
  logic            hit;
  logic            out_free;

  // hold off input while in reset and while a word is being worked on
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // saturate the signed reading to 0..100
  assign raw = in_tdata[RAW_W-1:0];
  always_comb begin
    if (raw[RAW_W-1]) begin
      sample = LEVEL_MIN;
    end else if (raw[RAW_W-2:0] > {1'b0, LEVEL_MAX}) begin
      sample = LEVEL_MAX;
    end else begin
      sample = raw[LEVEL_W-1:0];
    end
  end

  blmsf_ring #(.WINDOW(WINDOW)) u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (in_accept),
    .wr_data    (sample),
    .rd_idx     (cand_r),
    .rd_data    (cand_val),
    .entries    (entries),
    .held_count (held_count)
  );

  blmsf_rank #(.WINDOW(WINDOW)) u_rank (
    .entries    (entries),
    .held_count (held_count),
    .cand       (cand_val),
    .lt_count   (lt_count),
    .eq_count   (eq_count)
  );

  // the median sits at sorted index count/2; a candidate covers ranks lt..lt+eq-1
  assign rank_k   = held_count >> 1;
  assign upper    = {1'b0, lt_count} + {1'b0, eq_count};
  assign hit      = (lt_count <= rank_k) && ({1'b0, rank_k} < upper);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    cand_nxt       = cand_r;
    median_nxt     = median_r;
    shown_nxt      = shown_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r;
    out_shown_nxt  = out_shown_r;
    out_median_nxt = out_median_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cand_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // rank one held sample per cycle; advance until the median is hit
        if (hit) begin
          median_nxt = cand_val;
          state_nxt  = S_EMIT;
        end else begin
          cand_nxt = cand_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          // jump on the first sample, then step by one toward the median
          if (!valid_r) begin
            shown_nxt = median_r;
          end else if (median_r > shown_r) begin
            shown_nxt = shown_r + 1'b1;
          end else if (median_r < shown_r) begin
            shown_nxt = shown_r - 1'b1;
          end
          valid_nxt      = 1'b1;
          out_valid_nxt  = 1'b1;
          out_shown_nxt  = shown_nxt;
          out_median_nxt = median_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      shown_r     <= '0;
      valid_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      shown_r     <= shown_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r       <= cand_nxt;
    median_r     <= median_nxt;
    out_shown_r  <= out_shown_nxt;
    out_median_r <= out_median_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_median_r, out_shown_r};
  assign out_tuser  = 1'b1;

  // the scan never ranks an entry beyond the held samples
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ({1'b0, cand_r} < (IW + 1)'(held_count)))
    else $error("candidate index beyond held samples");

  // a taken word starts a scan with a non-empty ring
  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_SCAN) && (held_count != '0))
    else $error("accepted word did not start a scan");

  // the displayed level stays within range once valid
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (shown_r <= LEVEL_MAX))
    else $error("displayed level out of range");

  // a loaded result always reports a valid level
  a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> valid_r && (out_shown_r == shown_r))
    else $error("result loaded without a valid level");

endmodule

// ===== rtl/blmsf_ring.sv =====
// Sample ring: write pointer, fill count and one candidate read port.
module blmsf_ring import blmsf_pkg::*; #(
  parameter int unsigned WINDOW = 5,
  localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int unsigned CW = $clog2(WINDOW + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  level_t         wr_data,
  input  logic [IW-1:0]  rd_idx,
  output level_t         rd_data,
  output level_t         entries [WINDOW],
  output logic [CW-1:0]  held_count
);

  level_t          ring_r [WINDOW];
  logic [IW-1:0]   slot_r, slot_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  always_comb begin
    slot_nxt  = slot_r;
    count_nxt = count_r;
    if (wr_en) begin
      if (slot_r == IW'(WINDOW - 1)) begin
        slot_nxt = '0;
      end else begin
        slot_nxt = slot_r + 1'b1;
      end
      if (count_r != CW'(WINDOW)) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      count_r <= '0;
    end else begin
      slot_r  <= slot_nxt;
      count_r <= count_nxt;
    end
  end

  // storage holds no reset; only entries below the fill count are ever used
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_r[slot_r] <= wr_data;
    end
  end

  assign rd_data    = ring_r[rd_idx];
  assign entries    = ring_r;
  assign held_count = count_r;

endmodule

// ===== rtl/blmsf_rank.sv =====
// Shared rank unit: counts held samples below and equal to one candidate.
module blmsf_rank import blmsf_pkg::*; #(
  parameter int unsigned WINDOW = 5,
  localparam int unsigned CW = $clog2(WINDOW + 1)
) (
  input  level_t         entries [WINDOW],
  input  logic [CW-1:0]  held_count,
  input  level_t         cand,
  output logic [CW-1:0]  lt_count,
  output logic [CW-1:0]  eq_count
);

  always_comb begin
    lt_count = '0;
    eq_count = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (CW'(j) < held_count) begin
        if (entries[j] < cand) begin
          lt_count = lt_count + 1'b1;
        end
        if (entries[j] == cand) begin
          eq_count = eq_count + 1'b1;
        end
      end
    end
  end

endmodule

// ===== tb/tb_battery_level_median_slew_filter.sv =====
// Testbench for the battery level median and slew filter: directed and random readings against a predictor.
`timescale 1ns / 1ps

module tb_battery_level_median_slew_filter;
  import blmsf_pkg::*;

  localparam int unsigned WINDOW      = 5;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_READINGS = 1800;
  localparam int unsigned LONG_HOLD   = 90;

  // One expected result word, as the block reports it.
  typedef struct packed {
    level_t shown;
    logic   valid;
    level_t median;
  } level_result_t;

  // Tracks the filter state and queues the level each accepted reading should give.
  class level_scoreboard;
    level_t        ring [WINDOW];
    int unsigned   slot;
    int unsigned   held;
    bit            started;
    level_t        shown;
    level_result_t levels_due [$];
    int unsigned   mismatches;

    function new();
      slot       = 0;
      held       = 0;
      started    = 0;
      shown      = LEVEL_MIN;
      mismatches = 0;
      foreach (ring[i]) ring[i] = LEVEL_MIN;
    endfunction

    function level_t clamp_reading(logic [8:0] raw);
      if (raw[8]) return LEVEL_MIN;
      if (raw[7:0] > 8'(LEVEL_MAX)) return LEVEL_MAX;
      return raw[6:0];
    endfunction

    // Median of the held samples: upper middle of the ascending order.
    function level_t held_median();
      level_t      sorted [WINDOW];
      level_t      key;
      int unsigned j;
      for (int unsigned i = 0; i < held; i++) sorted[i] = ring[i];
      for (int unsigned i = 1; i < held; i++) begin
        key = sorted[i];
        j   = i;
        while (j > 0 && sorted[j-1] > key) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = key;
      end
      return sorted[held/2];
    endfunction

    function void note_reading(logic [8:0] raw);
      level_t        target;
      level_result_t due;
      ring[slot] = clamp_reading(raw);
      slot       = (slot + 1) % WINDOW;
      if (held < WINDOW) held++;
      target = held_median();
      if (!started) begin
        shown   = target;
        started = 1;
      end else if (target > shown) begin
        shown = shown + 1'b1;
      end else if (target < shown) begin
        shown = shown - 1'b1;
      end
      due.shown  = shown;
      due.valid  = 1'b1;
      due.median = target;
      levels_due.push_back(due);
    endfunction

    function void check_result(logic [15:0] data, logic user);
      level_result_t got;
      level_result_t due;
      got.shown  = data[6:0];
      got.valid  = user;
      got.median = data[13:7];
      if (levels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: shown %0d valid %0d median %0d",
                   got.shown, got.valid, got.median);
        return;
      end
      due = levels_due.pop_front();
      if (got !== due) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected shown %0d valid %0d median %0d,",
                    " got shown %0d valid %0d median %0d"},
                   due.shown, due.valid, due.median, got.shown, got.valid, got.median);
      end
    endfunction

    function int unsigned pending();
      return levels_due.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;

  level_scoreboard sb = new();

  bit          quiet_run;     // both sides run without gaps while set
  bit          hold_off_req;  // ask the receiver for one long stall
  int          walk_level;    // slowly drifting "true" battery level
  int unsigned cycles;

  battery_level_median_slew_filter #(.WINDOW(WINDOW)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // Abort a run that hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("battery_level_median_slew_filter test failed");
      $finish;
    end
  end

  // Check every word the block hands over, against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // Offer one reading after a random gap; hold it until the block takes it.
  task automatic send_reading(logic [8:0] raw);
    int unsigned gap;
    gap = quiet_run ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, raw};
    do @(posedge clk); while (!in_tready);
    sb.note_reading(raw);
  endtask

  // Mostly a drifting level with small noise, now and then a jump, a fresh
  // in-range value or an arbitrary 9-bit word (possibly negative or above 100).
  function automatic logic [8:0] next_reading();
    int unsigned pick;
    int          r;
    pick = $urandom_range(0, 99);
    if (pick < 5) walk_level = $urandom_range(0, 100);
    if (pick < 70) begin
      walk_level = walk_level + $urandom_range(0, 4) - 2;
      if (walk_level < 0) walk_level = 0;
      if (walk_level > 100) walk_level = 100;
      r = walk_level + $urandom_range(0, 6) - 3;
      return r[8:0];
    end
    if (pick < 85) return 9'($urandom_range(0, 100));
    return 9'($urandom_range(0, 511));
  endfunction

  // Receiver: random stall before each word, and one long hold-off on request
  // so the output register fills and the block stops taking input.
  initial begin
    int unsigned stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = quiet_run ? 0 : $urandom_range(0, 6);
      if (hold_off_req) begin
        stall        = LONG_HOLD;
        hold_off_req = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  initial begin
    logic [8:0] directed [$];
    cycles       = 0;
    quiet_run    = 0;
    hold_off_req = 0;
    walk_level   = 60;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Out of range both ways while the ring fills, then a level held at the
    // median, a full ring overwriting its oldest entries and slews both ways.
    directed = '{9'd255, 9'h100, 9'h1FF, 9'd0, 9'd101, 9'd100, 9'd50, 9'd50,
                 9'd1, 9'd99, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd100, 9'd100,
                 9'd100, 9'd100, 9'd100, 9'd100, 9'h180, 9'd127};
    foreach (directed[i]) send_reading(directed[i]);

    for (int unsigned n = 0; n < RANDOM_READINGS; n++) begin
      case (n)
        300: quiet_run = 1;
        500: quiet_run = 0;
        700: hold_off_req = 1;
        1100: begin
          // drop the offer and hold back until every pending word has arrived
          in_tvalid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
        end
        1500: quiet_run = 1;
        1600: quiet_run = 0;
        default: ;
      endcase
      send_reading(next_reading());
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (WINDOW + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("battery_level_median_slew_filter test passed");
    end else begin
      $display("battery_level_median_slew_filter test failed");
    end
    $finish;
  end

endmodule
